// ----- rtl/ttcw_pkg.sv -----
// Package for the text terminal cell writer.
// Screen geometry, character codes, cell addressing and the structs shared by the modules.
// No dependencies.
package ttcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // transaction field widths
    localparam int OP_W      = 1;
    localparam int BYTE_W    = 8;
    localparam int RROW_W    = 5;
    localparam int RCOL_W    = 7;
    localparam int CHAR_W    = 7;
    localparam int CUR_COL_W = 7;
    localparam int CUR_ROW_W = 5;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    localparam t_char CH_BS    = 7'h08;
    localparam t_char CH_TAB   = 7'h09;
    localparam t_char CH_LF    = 7'h0A;
    localparam t_char CH_CR    = 7'h0D;
    localparam t_char CH_SPACE = 7'h20;
    localparam t_char CH_TILDE = 7'h7E;
    localparam t_char CH_BLANK = CH_SPACE;

    localparam int TAB_STEP = 8;

    localparam logic [COL_W:0] COLS_E   = (COL_W+1)'(COLUMNS);
    localparam t_col           COLS_M1  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0] TAB_E    = (COL_W+1)'(TAB_STEP);
    localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(TAB_STEP - 1));
    localparam logic [ROW_W:0] ROWS_E   = (ROW_W+1)'(ROWS);
    localparam t_row           ROWS_M1  = ROW_W'(ROWS - 1);
    localparam t_addr          COLS_A   = ADDR_W'(COLUMNS);
    localparam t_addr          CELLS_M1 = ADDR_W'(CELLS - 1);
    localparam t_addr          COLS_A_M1 = ADDR_W'(COLUMNS - 1);

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_char wdata;
        t_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic [CHAR_W-1:0]    cell_char;
        logic [CUR_COL_W-1:0] cursor_col;
        logic [CUR_ROW_W-1:0] cursor_row;
    } t_result;

    // store row shown at a visible row
    function automatic t_row phys_row(t_row top, t_row vis);
        logic [ROW_W:0] s;
        s = {1'b0, top} + {1'b0, vis};
        if (s >= ROWS_E) begin
            s = s - ROWS_E;
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic t_addr cell_addr(t_row row, t_col col);
        return (ADDR_W'(row) * COLS_A) + ADDR_W'(col);
    endfunction

endpackage

// ----- rtl/ttcw_if.sv -----
// Handshake interfaces for the text terminal cell writer.
// Input item channel and result channel; depends on ttcw_pkg.
interface ttcw_in_if import ttcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] byte_value;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (output valid, output opcode, output byte_value, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input opcode, input byte_value, input read_row,
                    input read_col, output ready);
endinterface

interface ttcw_out_if import ttcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    cell_char;
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;

    modport source (output valid, output cell_char, output cursor_col, output cursor_row,
                    input ready);
    modport sink   (input valid, input cell_char, input cursor_col, input cursor_row,
                    output ready);
endinterface

// ----- rtl/ttcw_ram.sv -----
// Screen cell store: one write port, one read port, registered read data.
// Depends on ttcw_pkg.
module ttcw_ram import ttcw_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_char    o_rdata
);

    t_char r_mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// ----- rtl/ttcw_ctrl.sv -----
// Terminal sequencer: input transaction, cursor, scroll pointer, store clearing and access.
// Depends on ttcw_pkg, ttcw_in_if; drives ttcw_ram.
module ttcw_ctrl import ttcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ttcw_in_if.sink  i_in,
    output t_ram_req o_ram_req,
    input  t_char    i_rdata,
    output logic     o_res_valid,
    output t_result  o_res,
    input  logic     i_res_ready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    t_char             r_byte, n_byte;
    logic [RROW_W-1:0] r_rrow, n_rrow;
    logic [RCOL_W-1:0] r_rcol, n_rcol;
    t_col              r_col, n_col;
    t_row              r_row, n_row;
    t_row              r_top, n_top;
    t_char             r_char, n_char;
    t_addr             r_cnt, n_cnt;
    t_addr             r_base, n_base;

    logic              lf;
    logic [COL_W:0]    tab;
    logic [COL_W:0]    inc;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res.cell_char  = r_char;
    assign o_res.cursor_col = CUR_COL_W'(r_col);
    assign o_res.cursor_row = CUR_ROW_W'(r_row);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_byte  = r_byte;
        n_rrow  = r_rrow;
        n_rcol  = r_rcol;
        n_col   = r_col;
        n_row   = r_row;
        n_top   = r_top;
        n_char  = r_char;
        n_cnt   = r_cnt;
        n_base  = r_base;
        lf      = 1'b0;
        tab     = (({1'b0, r_col} + TAB_E) & TAB_MASK);
        inc     = {1'b0, r_col} + 1'b1;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_base + r_cnt;
        o_ram_req.wdata = CH_BLANK;
        o_ram_req.raddr = cell_addr(phys_row(r_top, t_row'(r_rrow)), t_col'(r_rcol));

        case (r_state)
            ST_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_cnt;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CELLS_M1) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.opcode;
                    n_byte  = i_in.byte_value[CHAR_W-1:0];
                    n_rrow  = i_in.read_row;
                    n_rcol  = i_in.read_col;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_op == OP_READ) begin
                    n_char  = CH_BLANK;
                    n_state = ST_DONE;
                    if (int'(r_rrow) < ROWS && int'(r_rcol) < COLUMNS) begin
                        n_state = ST_READ;
                    end
                end else begin
                    n_char  = '0;
                    n_state = ST_DONE;
                    case (r_byte) inside
                        CH_CR: n_col = '0;
                        CH_LF: lf = 1'b1;
                        CH_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        CH_TAB: begin
                            if (tab >= COLS_E) begin
                                n_col = COLS_M1;
                            end else begin
                                n_col = tab[COL_W-1:0];
                            end
                        end
                        [CH_SPACE:CH_TILDE]: begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = cell_addr(phys_row(r_top, r_row), r_col);
                            o_ram_req.wdata = r_byte;
                            if (inc >= COLS_E) begin
                                n_col = '0;
                                lf    = 1'b1;
                            end else begin
                                n_col = inc[COL_W-1:0];
                            end
                        end
                        default: ;
                    endcase
                    if (lf) begin
                        if (r_row == ROWS_M1) begin
                            // old top row becomes the blank bottom row
                            n_base  = cell_addr(r_top, '0);
                            n_cnt   = '0;
                            n_top   = (r_top == ROWS_M1) ? '0 : r_top + 1'b1;
                            n_state = ST_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                n_char  = i_rdata;
                n_state = ST_DONE;
            end
            ST_SCROLL: begin
                o_ram_req.we = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == COLS_A_M1) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_top   <= n_top;
            r_op    <= n_op;
            r_byte  <= n_byte;
            r_rrow  <= n_rrow;
            r_rcol  <= n_rcol;
            r_char  <= n_char;
            r_base  <= n_base;
        end
    end

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_in.ready)
        else $error("input taken during clearing pass");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_EXEC))
        else $error("accepted transaction not executed");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_req.we |-> (r_state == ST_CLEAR || r_state == ST_EXEC || r_state == ST_SCROLL))
        else $error("store write outside clear, execute or scroll");

    a_scroll_at_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> (r_row == ROWS_M1))
        else $error("scroll with cursor above bottom row");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (int'(r_col) < COLUMNS && int'(r_row) < ROWS))
        else $error("cursor outside screen");
`endif

endmodule

// ----- rtl/text_terminal_cell_writer.sv -----
// Text terminal cell writer: put and read transactions over an 80 x 25 screen store.
// A put passes the execute state and an in-range read the execute and read states; the result
// is then registered at the output. A put that scrolls adds a sweep over COLUMNS (80) cells
// that blanks the new bottom row. One transaction at a time; the sequencer takes no overlap.
// Reset: cursor and top row go to zero, then a clearing pass fills all 2000 store cells with
// spaces while input ready stays low. Depends on ttcw_pkg, ttcw_if, ttcw_ctrl, ttcw_ram.
module text_terminal_cell_writer import ttcw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttcw_in_if.sink   i_in,
    ttcw_out_if.source o_out
);

    t_ram_req ram_req;
    t_char    rdata;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    logic     r_out_valid;
    t_result  r_out;

    ttcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_ram_req   (ram_req),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    ttcw_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    assign res_ready        = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.cell_char  = r_out.cell_char;
    assign o_out.cursor_col = r_out.cursor_col;
    assign o_out.cursor_row = r_out.cursor_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
